/* rtl/ros_pkg.sv */
// shared types and constants for the ray / oriented-box slab test
// no dependencies
package ros_pkg;

  localparam int FRAC_BITS = 16;
  localparam int AX_W     = 18;
  localparam int POS_W    = 32;
  localparam int DL_W     = 33;
  localparam int PROD_W   = AX_W + DL_W;
  localparam int ACC_W    = 53;
  localparam int FDOT_W   = 38;
  localparam int DIST_W   = 48;
  localparam int S_DATA_W = 216;
  localparam int M_DATA_W = 8;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } ros_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DOT,
    S_EVAL,
    S_DIV_LO,
    S_DIV_HI,
    S_ORD,
    S_UPD,
    S_CHK,
    S_FIN
  } ros_state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } ros_mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ros_div_stat_t;

endpackage

/* rtl/ros_mac.sv */
// shared multiply-accumulate unit for the two dot products
// depends on ros_pkg
module ros_mac (
  input  logic                              clk,
  input  ros_pkg::ros_mac_ctl_t             ctl,
  input  logic signed [ros_pkg::AX_W-1:0]   a,
  input  logic signed [ros_pkg::DL_W-1:0]   b,
  output logic signed [ros_pkg::ACC_W-1:0]  acc
);
  import ros_pkg::*;

  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a * b;
    end
    if (ctl.acc_load) begin
      acc <= ACC_W'(prod);
    end else if (ctl.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

/* rtl/ros_div.sv */
// radix-2 restoring divider, one quotient bit per cycle, signed with saturation
// depends on ros_pkg
module ros_div #(
  parameter int DVD_W = 54,
  parameter int DVS_W = 22
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [DVD_W-1:0]            dividend,
  input  logic signed [DVS_W-1:0]            divisor,
  output ros_pkg::ros_div_stat_t             stat,
  output logic signed [ros_pkg::DIST_W-1:0]  quot
);
  import ros_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam logic signed [DIST_W-1:0] DMAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DMIN = {1'b1, {(DIST_W-1){1'b0}}};

  logic             busy;
  logic             done;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dq;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             take;
  logic             ovf;

  assign rem_sh  = {rem, dq[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign take    = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
      dvs <= divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
      rem <= '0;
      neg <= dividend[DVD_W-1] ^ divisor[DVS_W-1];
    end else if (busy) begin
      rem <= take ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      dq  <= {dq[DVD_W-2:0], take};
    end
  end

  assign ovf = |dq[DVD_W-1:DIST_W-1];

  always_comb begin
    if (neg) begin
      quot = ovf ? DMIN : -$signed(dq[DIST_W-1:0]);
    end else begin
      quot = ovf ? DMAX : $signed(dq[DIST_W-1:0]);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* rtl/ray_obb_slab_intersect_core.sv */
// ray versus oriented-box slab test: top level, register file and sequencer
// depends on ros_pkg, ros_mac, ros_div
//
//  port group   dir  contents
//  s_t*         in   slab word: axis xyz, center xyz, slab low/high; tlast closes a box
//  m_t*         out  hit word, one per box
//  p*           in   apb registers: ray origin xyz, ray direction xyz
//
// a slab on the division path runs the bit-serial divider twice, for the low and the high
// slab plane; a near-parallel slab skips the divider, and a slab after a miss goes
// straight to the finish state. the dot products share one multiplier.
// synchronous reset restores the interval, clears the miss flag and the ray origin, and sets the ray direction to +z.
// s_tready is high only between slabs; a held hit word stalls only a closing slab.
module ray_obb_slab_intersect_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // axis_x, axis_y, axis_z, center_x, center_y, center_z, slab_low, slab_high
  input  logic [ros_pkg::S_DATA_W-1:0]    s_tdata,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // hit
  output logic [ros_pkg::M_DATA_W-1:0]    m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ros_pkg::APB_AW-1:0]      paddr,
  input  logic [ros_pkg::APB_DW-1:0]      pwdata,
  output logic [ros_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import ros_pkg::*;

  localparam int E_W        = ACC_W - FRAC_BITS;
  localparam int F_W        = FDOT_W - FRAC_BITS;
  localparam int NUM_W      = ((E_W > POS_W) ? E_W : POS_W) + 1;
  localparam int DVD_W      = NUM_W + FRAC_BITS;
  localparam int PAR_THRESH = ((1 << FRAC_BITS) + 500) / 1000;
  localparam logic signed [DIST_W-1:0] FAR_RESET = DIST_W'(64'd100000 << FRAC_BITS);

  ros_state_t state, state_next;

  logic signed [POS_W-1:0] origin [3];
  logic signed [AX_W-1:0]  dir    [3];
  logic signed [AX_W-1:0]  ax     [3];
  logic signed [POS_W-1:0] ctr    [3];
  logic signed [POS_W-1:0] lo;
  logic signed [POS_W-1:0] hi;
  logic                    last_r;

  logic [2:0]              cnt;
  logic [1:0]              sel;
  logic signed [E_W-1:0]   e_reg;
  logic signed [DIST_W-1:0] t1;
  logic signed [DIST_W-1:0] t2;
  logic signed [DIST_W-1:0] near_dist;
  logic signed [DIST_W-1:0] far_dist;
  logic                    missed;
  logic                    hit_r;

  ros_mac_ctl_t            mac_ctl;
  logic signed [AX_W-1:0]  mac_a;
  logic signed [DL_W-1:0]  mac_b;
  logic signed [ACC_W-1:0] acc;

  logic signed [F_W-1:0]   f_val;
  logic [F_W-1:0]          f_mag;
  logic                    div_path;
  logic signed [NUM_W-1:0] num_lo;
  logic signed [NUM_W-1:0] num_hi;
  logic signed [NUM_W-1:0] diff_lo;
  logic signed [NUM_W-1:0] diff_hi;
  logic                    par_miss;
  logic                    div_start;
  logic signed [DVD_W-1:0] dvd;
  ros_div_stat_t           div_stat;
  logic signed [DIST_W-1:0] quot;

  logic                    in_acc;
  logic                    out_free;
  logic                    cfg_wr;

  // apb register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= '0;
      origin[1] <= '0;
      origin[2] <= '0;
      dir[0]    <= '0;
      dir[1]    <= '0;
      dir[2]    <= AX_W'(65536);
    end else if (cfg_wr) begin
      case (ros_reg_t'(paddr[4:2]))
        REG_ORIGIN_X: origin[0] <= pwdata[POS_W-1:0];
        REG_ORIGIN_Y: origin[1] <= pwdata[POS_W-1:0];
        REG_ORIGIN_Z: origin[2] <= pwdata[POS_W-1:0];
        REG_DIR_X:    dir[0]    <= pwdata[AX_W-1:0];
        REG_DIR_Y:    dir[1]    <= pwdata[AX_W-1:0];
        REG_DIR_Z:    dir[2]    <= pwdata[AX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ros_reg_t'(paddr[4:2]))
      REG_ORIGIN_X: prdata = origin[0];
      REG_ORIGIN_Y: prdata = origin[1];
      REG_ORIGIN_Z: prdata = origin[2];
      REG_DIR_X:    prdata = APB_DW'(unsigned'(dir[0]));
      REG_DIR_Y:    prdata = APB_DW'(unsigned'(dir[1]));
      REG_DIR_Z:    prdata = APB_DW'(unsigned'(dir[2]));
      default:      prdata = '0;
    endcase
  end

  // shared units
  assign sel   = (cnt < 3'd3) ? cnt[1:0] : 2'(cnt - 3'd3);
  assign mac_a = ax[sel];
  assign mac_b = (cnt < 3'd3) ? (DL_W'(ctr[sel]) - DL_W'(origin[sel])) : DL_W'(dir[sel]);

  ros_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  assign f_val    = acc[FDOT_W-1:FRAC_BITS];
  assign f_mag    = f_val[F_W-1] ? F_W'(-f_val) : F_W'(f_val);
  assign div_path = (32'(f_mag) > 32'(PAR_THRESH));
  assign num_lo   = NUM_W'(e_reg) + NUM_W'(lo);
  assign num_hi   = NUM_W'(e_reg) + NUM_W'(hi);
  assign diff_lo  = NUM_W'(lo) - NUM_W'(e_reg);
  assign diff_hi  = NUM_W'(hi) - NUM_W'(e_reg);
  assign par_miss = (!diff_lo[NUM_W-1] && (diff_lo != '0)) || diff_hi[NUM_W-1];
  assign dvd      = (state == S_EVAL) ? {num_lo, {FRAC_BITS{1'b0}}}
                                      : {num_hi, {FRAC_BITS{1'b0}}};

  ros_div #(
    .DVD_W (DVD_W),
    .DVS_W (F_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (f_val),
    .stat     (div_stat),
    .quot     (quot)
  );

  // sequencer
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_tvalid) state_next = missed ? S_FIN : S_DOT;
      S_DOT:    if (cnt == 3'd6) state_next = S_EVAL;
      S_EVAL:   state_next = div_path ? S_DIV_LO : S_FIN;
      S_DIV_LO: if (div_stat.done) state_next = S_DIV_HI;
      S_DIV_HI: if (div_stat.done) state_next = S_ORD;
      S_ORD:    state_next = S_UPD;
      S_UPD:    state_next = S_CHK;
      S_CHK:    state_next = S_FIN;
      S_FIN:    if (!last_r || out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready         = (state == S_IDLE);
    mac_ctl.mul_en   = (state == S_DOT) && (cnt <= 3'd5);
    mac_ctl.acc_load = (state == S_DOT) && ((cnt == 3'd1) || (cnt == 3'd4));
    mac_ctl.acc_add  = (state == S_DOT) && ((cnt == 3'd2) || (cnt == 3'd3) ||
                                            (cnt == 3'd5) || (cnt == 3'd6));
    div_start        = ((state == S_EVAL) && div_path) ||
                       ((state == S_DIV_LO) && div_stat.done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      missed    <= 1'b0;
      near_dist <= '0;
      far_dist  <= FAR_RESET;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_FIN) && last_r && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          cnt <= '0;
        end
        S_DOT: begin
          cnt <= cnt + 1'b1;
        end
        S_EVAL: begin
          if (!div_path && par_miss) begin
            missed <= 1'b1;
          end
        end
        S_UPD: begin
          if (t2 < far_dist) far_dist <= t2;
          if (t1 > near_dist) near_dist <= t1;
        end
        S_CHK: begin
          if (far_dist < near_dist) missed <= 1'b1;
        end
        S_FIN: begin
          if (last_r && out_free) begin
            missed    <= 1'b0;
            near_dist <= '0;
            far_dist  <= FAR_RESET;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax[0]  <= s_tdata[17:0];
      ax[1]  <= s_tdata[35:18];
      ax[2]  <= s_tdata[53:36];
      ctr[0] <= s_tdata[85:54];
      ctr[1] <= s_tdata[117:86];
      ctr[2] <= s_tdata[149:118];
      lo     <= s_tdata[181:150];
      hi     <= s_tdata[213:182];
      last_r <= s_tlast;
    end
    if ((state == S_DOT) && (cnt == 3'd4)) begin
      e_reg <= acc[ACC_W-1:FRAC_BITS];
    end
    if ((state == S_DIV_LO) && div_stat.done) begin
      t1 <= quot;
    end
    if ((state == S_DIV_HI) && div_stat.done) begin
      t2 <= quot;
    end
    if ((state == S_ORD) && (t1 > t2)) begin
      t1 <= t2;
      t2 <= t1;
    end
    if ((state == S_FIN) && last_r && out_free) begin
      hit_r <= !missed;
    end
  end

  assign m_tdata = {{(M_DATA_W-1){1'b0}}, hit_r};

  // checks
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_word_on_close: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FIN && last_r))
    else $error("hit word without a closing slab");

  a_interval_restore: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && last_r && out_free) |=>
      (near_dist == '0 && far_dist == FAR_RESET && !missed))
    else $error("interval not restored after a box");

  a_interval_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !missed) |-> (near_dist <= far_dist))
    else $error("empty interval without a miss");

endmodule
